[sv/utt_pkg.sv]
package utt_pkg;

    localparam int unsigned UnitW    = 16;
    localparam int unsigned ByteW    = 8;
    localparam int unsigned CpW      = 21;
    localparam int unsigned JobBytes = 6;
    localparam int unsigned CountW   = 3;
    localparam int unsigned QDepth   = 2;

    localparam logic [UnitW-1:0] HighFirst = 16'hd800;
    localparam logic [UnitW-1:0] HighLast  = 16'hdbff;
    localparam logic [UnitW-1:0] LowFirst  = 16'hdc00;
    localparam logic [UnitW-1:0] LowLast   = 16'hdfff;
    localparam logic [CpW-1:0]   SuppBase  = 21'h10000;
    localparam logic [CpW-1:0]   Replace   = 21'h0fffd;
    localparam logic [CpW-1:0]   Max1Byte  = 21'h0007f;
    localparam logic [CpW-1:0]   Max2Byte  = 21'h007ff;
    localparam logic [CpW-1:0]   Max3Byte  = 21'h0ffff;
    localparam logic [ByteW-1:0] Lead2     = 8'hc0;
    localparam logic [ByteW-1:0] Lead3     = 8'he0;
    localparam logic [ByteW-1:0] Lead4     = 8'hf0;
    localparam logic [ByteW-1:0] ContMark  = 8'h80;

    // Bytes of one input item, in emission order from index 0
    typedef struct packed {
        logic [JobBytes-1:0][ByteW-1:0] bytes;
        logic [CountW-1:0]              count;
        logic                           str_last;
    } job_t;

    typedef struct packed {
        logic [3:0][ByteW-1:0] b;
        logic [CountW-1:0]     len;
    } enc_t;

    function automatic enc_t utf8_encode(input logic [CpW-1:0] cp);
        enc_t e;
        e = '0;
        if (cp <= Max1Byte) begin
            e.b[0] = cp[7:0];
            e.len  = CountW'(1);
        end
        else if (cp <= Max2Byte) begin
            e.b[0] = Lead2 | {3'b000, cp[10:6]};
            e.b[1] = ContMark | {2'b00, cp[5:0]};
            e.len  = CountW'(2);
        end
        else if (cp <= Max3Byte) begin
            e.b[0] = Lead3 | {4'b0000, cp[15:12]};
            e.b[1] = ContMark | {2'b00, cp[11:6]};
            e.b[2] = ContMark | {2'b00, cp[5:0]};
            e.len  = CountW'(3);
        end
        else begin
            e.b[0] = Lead4 | {5'b00000, cp[20:18]};
            e.b[1] = ContMark | {2'b00, cp[17:12]};
            e.b[2] = ContMark | {2'b00, cp[11:6]};
            e.b[3] = ContMark | {2'b00, cp[5:0]};
            e.len  = CountW'(4);
        end
        return e;
    endfunction

endpackage

[sv/utf16_to_utf8_transcoder.sv]
// Throughput: one output byte per cycle while out_stall is low and requests are queued; a unit yields 0 to 6 bytes
// (none for a held high surrogate, 1 to 3 for a BMP unit, 4 for a surrogate pair).
// A two-entry queue parts input from output; requests are taken while bytes drain.
// Reset (rst_n low, asynchronous) drops any pending high surrogate, empties the
// queue and clears the output valid.
module utf16_to_utf8_transcoder
    import utt_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [UnitW-1:0] code_unit,
    input  logic             last_unit,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [ByteW-1:0] utf8_byte,
    output logic             run_last,
    output logic             string_last
);

    logic q_full;
    logic q_push;
    logic q_avail;
    logic q_pop;
    job_t push_job;
    job_t pop_job;

    utt_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .code_unit (code_unit),
        .last_unit (last_unit),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_job     (push_job)
    );

    utt_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (q_pop),
        .avail    (q_avail),
        .pop_job  (pop_job)
    );

    utt_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_avail     (q_avail),
        .q_job       (pop_job),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .utf8_byte   (utf8_byte),
        .run_last    (run_last),
        .string_last (string_last)
    );

endmodule

[sv/utt_front.sv]
module utt_front
    import utt_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [UnitW-1:0] code_unit,
    input  logic             last_unit,
    input  logic             q_full,
    output logic             q_push,
    output job_t             q_job
);

    logic       high_pending_reg;
    logic       high_pending_next;
    logic [9:0] high_bits_reg;
    logic [9:0] high_bits_next;

    logic           accept;
    logic           is_high;
    logic           is_low;
    logic           pair;
    logic           pre_fffd;
    logic           main_has;
    logic [CpW-1:0] main_cp;
    enc_t           main_enc;
    enc_t           pre_enc;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;

    assign is_high  = (code_unit >= HighFirst) && (code_unit <= HighLast);
    assign is_low   = (code_unit >= LowFirst) && (code_unit <= LowLast);
    assign pair     = high_pending_reg && is_low;
    assign pre_fffd = high_pending_reg && !is_low;
    assign main_has = !(is_high && !last_unit);

    always_comb
    begin
        priority if (pair)
            main_cp = SuppBase + {1'b0, high_bits_reg, code_unit[9:0]};
        else if (is_high || is_low)
            main_cp = Replace;
        else
            main_cp = {5'b00000, code_unit};
    end

    assign main_enc = utf8_encode(main_cp);
    assign pre_enc  = utf8_encode(Replace);

    always_comb
    begin
        q_job          = '0;
        q_job.str_last = last_unit;
        if (pre_fffd)
        begin
            for (int i = 0; i < 3; i++)
            begin
                q_job.bytes[i] = pre_enc.b[i];
            end
            if (main_has)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    q_job.bytes[i+3] = main_enc.b[i];
                end
            end
            q_job.count = pre_enc.len + (main_has ? main_enc.len : CountW'(0));
        end
        else
        begin
            for (int i = 0; i < 4; i++)
            begin
                q_job.bytes[i] = main_enc.b[i];
            end
            q_job.count = main_has ? main_enc.len : CountW'(0);
        end
    end

    // A stored high surrogate with nothing else gives no request downstream
    assign q_push = accept && (q_job.count != CountW'(0));

    always_comb
    begin
        high_pending_next = high_pending_reg;
        high_bits_next    = high_bits_reg;
        if (accept)
        begin
            high_pending_next = is_high && !last_unit;
            high_bits_next    = (is_high && !last_unit) ? code_unit[9:0] : 10'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            high_pending_reg <= 1'b0;
            high_bits_reg    <= 10'd0;
        end
        else
        begin
            high_pending_reg <= high_pending_next;
            high_bits_reg    <= high_bits_next;
        end
    end

endmodule

[sv/utt_queue.sv]
module utt_queue
    import utt_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    output logic full,
    input  logic pop,
    output logic avail,
    output job_t pop_job
);

    localparam int unsigned PtrW = (QDepth > 1) ? $clog2(QDepth) : 1;
    localparam int unsigned CntW = $clog2(QDepth + 1);

    job_t            mem_reg [QDepth];
    logic [PtrW-1:0] wr_ptr_reg;
    logic [PtrW-1:0] wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg;
    logic [PtrW-1:0] rd_ptr_next;
    logic [CntW-1:0] count_reg;
    logic [CntW-1:0] count_next;
    logic            do_push;
    logic            do_pop;

    assign full    = (count_reg == CntW'(QDepth));
    assign avail   = (count_reg != CntW'(0));
    assign pop_job = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && avail;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(QDepth - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(QDepth - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        unique case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

[sv/utt_back.sv]
module utt_back
    import utt_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_avail,
    input  job_t             q_job,
    output logic             q_pop,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [ByteW-1:0] utf8_byte,
    output logic             run_last,
    output logic             string_last
);

    job_t              cur_reg;
    job_t              cur_next;
    logic [CountW-1:0] idx_reg;
    logic [CountW-1:0] idx_next;
    logic              busy_reg;
    logic              busy_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [ByteW-1:0]  byte_reg;
    logic              run_last_reg;
    logic              string_last_reg;

    logic advance;
    logic finish;
    logic load;

    assign advance = busy_reg && (!out_valid_reg || !out_stall);
    assign finish  = advance && (idx_reg == cur_reg.count - CountW'(1));
    // Take the next request in the same cycle as the last byte of this one
    assign load    = q_avail && (!busy_reg || finish);
    assign q_pop   = load;

    always_comb
    begin
        cur_next  = cur_reg;
        idx_next  = idx_reg;
        busy_next = busy_reg;
        if (load)
        begin
            cur_next  = q_job;
            idx_next  = '0;
            busy_next = 1'b1;
        end
        else if (finish)
        begin
            busy_next = 1'b0;
        end
        else if (advance)
        begin
            idx_next = idx_reg + 1'b1;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        if (advance)
        begin
            byte_reg        <= cur_reg.bytes[idx_reg];
            run_last_reg    <= finish;
            string_last_reg <= finish && cur_reg.str_last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign utf8_byte   = byte_reg;
    assign run_last    = run_last_reg;
    assign string_last = string_last_reg;

endmodule

[sv/utt_checker.sv]
module utt_checker
    import utt_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             out_valid,
    input logic             out_stall,
    input logic [ByteW-1:0] utf8_byte,
    input logic             run_last,
    input logic             string_last
);

    // Stalled output holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(utf8_byte) && $stable(run_last)
            && $stable(string_last))
        else $error("output changed while stalled");

    a_str_run: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && string_last |-> run_last)
        else $error("string end without request end");

    a_lead_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && run_last |-> utf8_byte[7:6] != 2'b11)
        else $error("request ended on a lead byte");

    // Bytes of one code point leave back to back
    a_cont_follows: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && utf8_byte[7:6] == 2'b11
            |=> out_valid && utf8_byte[7:6] == 2'b10)
        else $error("continuation byte missing after lead byte");

    a_legal_byte: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> utf8_byte[7:3] != 5'b11111)
        else $error("illegal UTF-8 byte");

endmodule

bind utf16_to_utf8_transcoder utt_checker u_utt_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .utf8_byte   (utf8_byte),
    .run_last    (run_last),
    .string_last (string_last)
);

[tb/tb_utf16_to_utf8_transcoder.sv]
module tb_utf16_to_utf8_transcoder;

    import utt_pkg::*;

    localparam int IdleLimit = 1000;
    localparam int DrainWait = 10;

    typedef struct packed {
        logic [ByteW-1:0] data;
        logic             run_end;
        logic             str_end;
    } utf8_rec_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             in_valid = 1'b0;
    logic             in_stall;
    logic [UnitW-1:0] code_unit = '0;
    logic             last_unit = 1'b0;
    logic             out_valid;
    logic             out_stall = 1'b0;
    logic [ByteW-1:0] utf8_byte;
    logic             run_last;
    logic             string_last;

    // Expected UTF-8 bytes, oldest first
    utf8_rec_t        utf8_queue[$];
    logic [ByteW-1:0] run_bytes[$];

    // Predictor copy of the surrogate state
    logic             surr_held = 1'b0;
    logic [9:0]       surr_bits = '0;

    int mismatches = 0;
    int items_sent = 0;
    int idle_cycles = 0;
    int stall_cnt = 0;
    bit quiet = 1'b0;

    utf16_to_utf8_transcoder dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .code_unit   (code_unit),
        .last_unit   (last_unit),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .utf8_byte   (utf8_byte),
        .run_last    (run_last),
        .string_last (string_last)
    );

    always #5 clk = ~clk;

    // Mostly no gap, some short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 50)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    function automatic void put_byte(input logic [ByteW-1:0] b);
        run_bytes = {run_bytes, b};
    endfunction

    function automatic void add_code_point(input logic [CpW-1:0] cp);
        if (cp <= 21'h7f) begin
            put_byte(cp[7:0]);
        end
        else if (cp <= 21'h7ff) begin
            put_byte({3'b110, cp[10:6]});
            put_byte({2'b10, cp[5:0]});
        end
        else if (cp <= 21'hffff) begin
            put_byte({4'b1110, cp[15:12]});
            put_byte({2'b10, cp[11:6]});
            put_byte({2'b10, cp[5:0]});
        end
        else begin
            put_byte({5'b11110, cp[20:18]});
            put_byte({2'b10, cp[17:12]});
            put_byte({2'b10, cp[11:6]});
            put_byte({2'b10, cp[5:0]});
        end
    endfunction

    function automatic void predict_utf8(input logic [UnitW-1:0] unit, input logic last);
        logic      is_high;
        logic      is_low;
        logic      paired;
        utf8_rec_t rec;
        is_high = (unit >= HighFirst) && (unit <= HighLast);
        is_low  = (unit >= LowFirst) && (unit <= LowLast);
        paired  = 1'b0;
        run_bytes.delete();
        if (surr_held) begin
            surr_held = 1'b0;
            if (is_low) begin
                add_code_point(SuppBase + {surr_bits, unit[9:0]});
                paired = 1'b1;
            end
            else begin
                // unpaired high: replacement first, then treat the unit afresh
                add_code_point(Replace);
            end
            surr_bits = '0;
        end
        if (!paired) begin
            if (is_high) begin
                if (last) begin
                    add_code_point(Replace);
                end
                else begin
                    surr_held = 1'b1;
                    surr_bits = unit[9:0];
                end
            end
            else if (is_low) begin
                add_code_point(Replace);
            end
            else begin
                add_code_point({5'b0, unit});
            end
        end
        foreach (run_bytes[i]) begin
            rec.data    = run_bytes[i];
            rec.run_end = (i == run_bytes.size() - 1);
            rec.str_end = (i == run_bytes.size() - 1) && last;
            utf8_queue = {utf8_queue, rec};
        end
    endfunction

    task automatic note_mismatch(input string what);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch at %0t: %s", $realtime, what);
    endtask

    task automatic send_unit(input logic [UnitW-1:0] unit, input logic last);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid  <= 1'b1;
        code_unit <= unit;
        last_unit <= last;
        do
            @(posedge clk);
        while (in_stall);
        predict_utf8(unit, last);
        items_sent++;
    endtask

    // Output side back-pressure
    always @(negedge clk) begin
        if (stall_cnt != 0) begin
            stall_cnt <= stall_cnt - 1;
        end
        else if (!quiet && $urandom_range(0, 3) == 0) begin
            out_stall <= 1'b1;
            stall_cnt <= pick_gap();
        end
        else begin
            out_stall <= 1'b0;
        end
    end

    always @(posedge clk) begin
        utf8_rec_t want;
        if (rst_n && out_valid && !out_stall) begin
            if (utf8_queue.size() == 0) begin
                note_mismatch($sformatf("unexpected byte %02h run %0b str %0b",
                                        utf8_byte, run_last, string_last));
            end
            else begin
                want = utf8_queue.pop_front();
                if (utf8_byte !== want.data || run_last !== want.run_end ||
                    string_last !== want.str_end)
                    note_mismatch($sformatf(
                        "expected %02h run %0b str %0b, got %02h run %0b str %0b",
                        want.data, want.run_end, want.str_end,
                        utf8_byte, run_last, string_last));
            end
        end
    end

    // Watchdog: end the run if nothing moves for too long
    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IdleLimit) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    task automatic test_directed();
        // range edges of each encoding length
        send_unit(16'h0000, 1'b0);
        send_unit(16'h007f, 1'b0);
        send_unit(16'h0080, 1'b0);
        send_unit(16'h07ff, 1'b0);
        send_unit(16'h0800, 1'b0);
        send_unit(16'hd7ff, 1'b0);
        send_unit(16'he000, 1'b0);
        send_unit(16'hffff, 1'b1);
        // lowest and highest supplementary code points
        send_unit(16'hd800, 1'b0);
        send_unit(16'hdc00, 1'b0);
        send_unit(16'hdbff, 1'b0);
        send_unit(16'hdfff, 1'b1);
        // high surrogate at string end
        send_unit(16'hd800, 1'b1);
        // unpaired high followed by plain units
        send_unit(16'hd801, 1'b0);
        send_unit(16'h0041, 1'b0);
        send_unit(16'hdabc, 1'b0);
        send_unit(16'h20ac, 1'b1);
        // high then high then low
        send_unit(16'hd800, 1'b0);
        send_unit(16'hdbff, 1'b0);
        send_unit(16'hdfff, 1'b0);
        // lone low surrogates
        send_unit(16'hdc00, 1'b0);
        send_unit(16'hdfff, 1'b1);
        // pair closing a string
        send_unit(16'hd83d, 1'b0);
        send_unit(16'hde00, 1'b1);
    endtask

    task automatic send_text(input int target);
        int               stop_at;
        int               len;
        logic             fin;
        logic [UnitW-1:0] u;
        stop_at = items_sent + target;
        while (items_sent < stop_at) begin
            len = $urandom_range(1, 8);
            for (int i = 0; i < len; i++) begin
                fin = (i == len - 1);
                case ($urandom_range(0, 3))
                    0: send_unit(UnitW'($urandom_range(0, 16'h7f)), fin);
                    1: send_unit(UnitW'($urandom_range(16'h80, 16'h7ff)), fin);
                    2:
                    begin
                        u = UnitW'($urandom_range(16'h800, 16'hf7ff));
                        if (u >= HighFirst)
                            u = u + 16'h0800;
                        send_unit(u, fin);
                    end
                    default:
                    begin
                        send_unit(UnitW'($urandom_range(HighFirst, HighLast)), 1'b0);
                        send_unit(UnitW'($urandom_range(LowFirst, LowLast)), fin);
                    end
                endcase
            end
        end
    endtask

    task automatic test_random_text();
        send_text(45);
    endtask

    task automatic test_surrogate_noise();
        logic [UnitW-1:0] u;
        for (int i = 0; i < 30; i++) begin
            if ($urandom_range(0, 9) < 4)
                u = UnitW'($urandom_range(HighFirst, LowLast));
            else
                u = UnitW'($urandom_range(0, 16'hffff));
            send_unit(u, $urandom_range(0, 3) == 0);
        end
    endtask

    task automatic test_streaming();
        quiet = 1'b1;
        send_text(20);
        quiet = 1'b0;
    endtask

    initial begin
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_random_text();
        test_surrogate_noise();
        test_streaming();
        @(negedge clk);
        in_valid <= 1'b0;
        while (utf8_queue.size() != 0)
            @(posedge clk);
        repeat (DrainWait) @(posedge clk);
        if (utf8_queue.size() != 0)
            note_mismatch("bytes still expected at end of run");
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

[sim.f]
sv/utt_pkg.sv
sv/utt_front.sv
sv/utt_queue.sv
sv/utt_back.sv
sv/utf16_to_utf8_transcoder.sv
sv/utt_checker.sv
tb/tb_utf16_to_utf8_transcoder.sv
